@@ rtl/core/rpn_stack_calculator_defines.svh @@
// Assertion macros used by the checker file of the RPN stack calculator.
`ifndef RPN_STACK_CALCULATOR_DEFINES_SVH
`define RPN_STACK_CALCULATOR_DEFINES_SVH

// Concurrent assertion on an explicit clock and active-low reset.
`define RSC_ASSERT_CLK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// Concurrent assertion on the usual clk_i and rst_ni of the enclosing module.
`define RSC_ASSERT(label, prop, msg) \
  `RSC_ASSERT_CLK(label, clk_i, rst_ni, prop, msg)

`endif

@@ rtl/core/rsc_pkg.sv @@
// Package with widths, request and status codes and sequencer states of the RPN calculator.
`default_nettype none

package rsc_pkg;

  localparam int unsigned VALUE_W   = 48;
  localparam int unsigned TYPE_W    = 3;
  localparam int unsigned STATUS_W  = 3;
  localparam int unsigned CNT_W     = 6;
  localparam int unsigned STACK_DEPTH_DEF = 128;

  // Last loop index of the shared unit for multiply and for divide.
  localparam logic [CNT_W-1:0] MUL_LAST = 6'd47;
  localparam logic [CNT_W-1:0] DIV_LAST = 6'd63;

  // Saturation limits of the signed Q32.16 value.
  localparam logic [VALUE_W-1:0] VALUE_MIN = 48'h8000_0000_0000;
  localparam logic [VALUE_W-1:0] VALUE_MAX = 48'h7FFF_FFFF_FFFF;

  // Request codes.
  localparam logic [TYPE_W-1:0] REQ_PUSH    = 3'd0;
  localparam logic [TYPE_W-1:0] REQ_ADD     = 3'd1;
  localparam logic [TYPE_W-1:0] REQ_SUB     = 3'd2;
  localparam logic [TYPE_W-1:0] REQ_MUL     = 3'd3;
  localparam logic [TYPE_W-1:0] REQ_DIV     = 3'd4;
  localparam logic [TYPE_W-1:0] REQ_MOD     = 3'd5;
  localparam logic [TYPE_W-1:0] REQ_PRINT   = 3'd6;
  localparam logic [TYPE_W-1:0] REQ_UNKNOWN = 3'd7;

  // Status codes.
  localparam logic [STATUS_W-1:0] STS_OK       = 3'd0;
  localparam logic [STATUS_W-1:0] STS_PRINTED  = 3'd1;
  localparam logic [STATUS_W-1:0] STS_ZERO_DIV = 3'd2;
  localparam logic [STATUS_W-1:0] STS_FULL     = 3'd3;
  localparam logic [STATUS_W-1:0] STS_EMPTY    = 3'd4;
  localparam logic [STATUS_W-1:0] STS_UNKNOWN  = 3'd5;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_POP_B,
    ST_GET_B,
    ST_POP_A,
    ST_GET_A,
    ST_PREP,
    ST_ABS_A,
    ST_ABS_B,
    ST_MUL,
    ST_DIV,
    ST_PACK,
    ST_PUSH,
    ST_FINISH
  } state_e;

endpackage

`default_nettype wire

@@ rtl/core/rsc_req_if.sv @@
// Request channel of the RPN calculator: token type and number to push.
`default_nettype none

interface rsc_req_if;
  logic                                valid;
  logic                                ready;
  logic        [rsc_pkg::TYPE_W-1:0]   req_type;
  logic signed [rsc_pkg::VALUE_W-1:0]  number_value;

  modport source (output valid, output req_type, output number_value, input ready);
  modport sink   (input valid, input req_type, input number_value, output ready);
endinterface

`default_nettype wire

@@ rtl/core/rsc_rsp_if.sv @@
// Response channel of the RPN calculator: status and printed value.
`default_nettype none

interface rsc_rsp_if;
  logic                                valid;
  logic                                ready;
  logic        [rsc_pkg::STATUS_W-1:0] status;
  logic signed [rsc_pkg::VALUE_W-1:0]  result_value;

  modport source (output valid, output status, output result_value, input ready);
  modport sink   (input valid, input status, input result_value, output ready);
endinterface

`default_nettype wire

@@ rtl/core/rpn_stack_calculator.sv @@
// Top level of the RPN stack calculator: sequencer, shared adder unit and value stack memory.
//
//   Channel  Direction  Handshake      Payload
//   req_i    in         valid / ready  req_type, number_value
//   rsp_o    out        valid / ready  status, result_value
//
// One response transfer per request transfer, in order. The block works on one request at
// a time; multiply, divide and modulo run radix-2 loops on the shared 50-bit adder, one
// multiplier or quotient bit per step. Reset clears the sequencer, the stack pointer
// and the response valid; the stack memory is never cleared. A stalled response waits in
// the output register while the next request is taken and runs up to its last step.
`default_nettype none

module rpn_stack_calculator #(
  parameter int unsigned STACK_DEPTH = rsc_pkg::STACK_DEPTH_DEF
) (
  input  wire          clk_i,
  input  wire          rst_ni,
  rsc_req_if.sink      req_i,
  rsc_rsp_if.source    rsp_o
);

  localparam int unsigned VW  = rsc_pkg::VALUE_W;
  localparam int unsigned AW  = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int unsigned SPW = $clog2(STACK_DEPTH + 1);
  localparam int unsigned CW  = rsc_pkg::CNT_W;

  // Sequencer and control state.
  rsc_pkg::state_e              state_q, state_d;
  logic [SPW-1:0]               sp_q, sp_d;
  logic [rsc_pkg::TYPE_W-1:0]   op_q, op_d;
  logic [rsc_pkg::STATUS_W-1:0] status_q, status_d;
  logic                         empty_q, empty_d;   // some pop of this item found no entry
  logic                         pe_q, pe_d;         // the latest pop found no entry
  logic [CW-1:0]                cnt_q, cnt_d;

  // Operand and loop registers.
  logic [VW-1:0]   a_q, a_d;
  logic [VW-1:0]   b_q, b_d;
  logic [VW-1:0]   res_q, res_d;
  logic            neg_q, neg_d;
  logic [VW-1:0]   hi_q, hi_d;
  logic [VW-1:0]   lo_q, lo_d;
  logic [2*VW+15:0] dvd_q, dvd_d;
  logic [VW-1:0]   rem_q, rem_d;

  // Response register.
  logic                         rsp_valid_q;
  logic [rsc_pkg::STATUS_W-1:0] rsp_status_q;
  logic [VW-1:0]                rsp_value_q;

  // Stack memory with one write port and one registered read port.
  logic [VW-1:0] mem_q [STACK_DEPTH];
  logic [VW-1:0] rd_q;
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [VW-1:0] mem_wdata;
  logic          mem_re;
  logic [AW-1:0] mem_raddr;

  // The shared arithmetic unit: one 50-bit add or subtract.
  logic [VW+1:0] add_x, add_y, add_s;
  logic          add_sub;

  logic            req_fire;
  logic            rsp_load;
  logic [SPW-1:0]  sp_m1;
  logic [VW-1:0]   pop_val;
  logic            mag_big;
  logic [VW-1:0]   mag;
  logic            qbit;
  logic [rsc_pkg::STATUS_W-1:0] final_status;

  assign req_fire = req_i.valid && req_i.ready;
  assign rsp_load = (state_q == rsc_pkg::ST_FINISH) && (!rsp_valid_q || rsp_o.ready);
  assign sp_m1    = sp_q - 1'b1;
  // A pop of an empty stack reads as zero.
  assign pop_val  = pe_q ? '0 : rd_q;
  assign add_s    = add_x + (add_sub ? ~add_y : add_y) + {{(VW+1){1'b0}}, add_sub};
  assign qbit     = !add_s[VW+1];

  assign final_status = empty_q ? rsc_pkg::STS_EMPTY : status_q;

  // Next-state logic of the sequencer.
  always_comb begin
    state_d = state_q;
    case (state_q)
      rsc_pkg::ST_IDLE: begin
        if (req_fire) begin
          case (req_i.req_type)
            rsc_pkg::REQ_ADD, rsc_pkg::REQ_SUB, rsc_pkg::REQ_MUL,
            rsc_pkg::REQ_DIV, rsc_pkg::REQ_MOD, rsc_pkg::REQ_PRINT: state_d = rsc_pkg::ST_POP_B;
            default: state_d = rsc_pkg::ST_FINISH;
          endcase
        end
      end
      rsc_pkg::ST_POP_B: state_d = rsc_pkg::ST_GET_B;
      rsc_pkg::ST_GET_B: begin
        if (op_q == rsc_pkg::REQ_PRINT) begin
          state_d = rsc_pkg::ST_FINISH;
        end else if ((op_q inside {rsc_pkg::REQ_DIV, rsc_pkg::REQ_MOD}) && (pop_val == '0)) begin
          state_d = rsc_pkg::ST_FINISH;
        end else begin
          state_d = rsc_pkg::ST_POP_A;
        end
      end
      rsc_pkg::ST_POP_A: state_d = rsc_pkg::ST_GET_A;
      rsc_pkg::ST_GET_A: state_d = rsc_pkg::ST_PREP;
      rsc_pkg::ST_PREP: begin
        if (op_q inside {rsc_pkg::REQ_ADD, rsc_pkg::REQ_SUB}) begin
          state_d = rsc_pkg::ST_PUSH;
        end else begin
          state_d = rsc_pkg::ST_ABS_A;
        end
      end
      rsc_pkg::ST_ABS_A: state_d = rsc_pkg::ST_ABS_B;
      rsc_pkg::ST_ABS_B: begin
        state_d = (op_q == rsc_pkg::REQ_MUL) ? rsc_pkg::ST_MUL : rsc_pkg::ST_DIV;
      end
      rsc_pkg::ST_MUL: begin
        if (cnt_q == rsc_pkg::MUL_LAST) begin
          state_d = rsc_pkg::ST_PACK;
        end
      end
      rsc_pkg::ST_DIV: begin
        if (cnt_q == rsc_pkg::DIV_LAST) begin
          state_d = rsc_pkg::ST_PACK;
        end
      end
      rsc_pkg::ST_PACK: state_d = rsc_pkg::ST_PUSH;
      rsc_pkg::ST_PUSH: state_d = rsc_pkg::ST_FINISH;
      rsc_pkg::ST_FINISH: begin
        if (rsp_load) begin
          state_d = rsc_pkg::ST_IDLE;
        end
      end
      default: state_d = rsc_pkg::ST_IDLE;
    endcase
  end

  // Magnitude and overflow of the finished product, quotient or remainder.
  always_comb begin
    case (op_q)
      rsc_pkg::REQ_MUL: begin
        // The product shifted right by 16 is hi * 2^32 plus the upper bits of lo.
        mag_big = (hi_q[VW-1:16] != '0);
        mag     = {hi_q[15:0], lo_q[VW-1:16]};
      end
      rsc_pkg::REQ_DIV: begin
        mag_big = (dvd_q[2*VW+15:VW] != '0);
        mag     = dvd_q[VW-1:0];
      end
      default: begin
        mag_big = 1'b0;
        mag     = rem_q;
      end
    endcase
  end

  // Datapath and memory controls: one sequencer step per cycle unless IDLE or FINISH waits.
  always_comb begin
    sp_d      = sp_q;
    op_d      = op_q;
    status_d  = status_q;
    empty_d   = empty_q;
    pe_d      = pe_q;
    cnt_d     = cnt_q;
    a_d       = a_q;
    b_d       = b_q;
    res_d     = res_q;
    neg_d     = neg_q;
    hi_d      = hi_q;
    lo_d      = lo_q;
    dvd_d     = dvd_q;
    rem_d     = rem_q;
    mem_we    = 1'b0;
    mem_waddr = sp_q[AW-1:0];
    mem_wdata = res_q;
    mem_re    = 1'b0;
    mem_raddr = sp_m1[AW-1:0];
    add_x     = '0;
    add_y     = '0;
    add_sub   = 1'b0;

    case (state_q)
      rsc_pkg::ST_IDLE: begin
        if (req_fire) begin
          op_d     = req_i.req_type;
          empty_d  = 1'b0;
          status_d = rsc_pkg::STS_OK;
          res_d    = '0;
          case (req_i.req_type)
            rsc_pkg::REQ_PUSH: begin
              if (sp_q < SPW'(STACK_DEPTH)) begin
                mem_we    = 1'b1;
                mem_wdata = req_i.number_value;
                sp_d      = sp_q + 1'b1;
              end else begin
                status_d = rsc_pkg::STS_FULL;
              end
            end
            rsc_pkg::REQ_UNKNOWN: status_d = rsc_pkg::STS_UNKNOWN;
            default: ;
          endcase
        end
      end
      rsc_pkg::ST_POP_B, rsc_pkg::ST_POP_A: begin
        if (sp_q == '0) begin
          pe_d    = 1'b1;
          empty_d = 1'b1;
        end else begin
          pe_d   = 1'b0;
          mem_re = 1'b1;
          sp_d   = sp_m1;
        end
      end
      rsc_pkg::ST_GET_B: begin
        b_d = pop_val;
        if (op_q == rsc_pkg::REQ_PRINT) begin
          res_d    = pop_val;
          status_d = rsc_pkg::STS_PRINTED;
        end else if ((op_q inside {rsc_pkg::REQ_DIV, rsc_pkg::REQ_MOD}) && (pop_val == '0)) begin
          status_d = rsc_pkg::STS_ZERO_DIV;
        end
      end
      rsc_pkg::ST_GET_A: a_d = pop_val;
      rsc_pkg::ST_PREP: begin
        if (op_q inside {rsc_pkg::REQ_ADD, rsc_pkg::REQ_SUB}) begin
          add_x   = {{2{a_q[VW-1]}}, a_q};
          add_y   = {{2{b_q[VW-1]}}, b_q};
          add_sub = (op_q == rsc_pkg::REQ_SUB);
          // The exact sum fits in 49 bits; bits 48 and 47 differ on overflow.
          if (add_s[VW] != add_s[VW-1]) begin
            res_d = add_s[VW] ? rsc_pkg::VALUE_MIN : rsc_pkg::VALUE_MAX;
          end else begin
            res_d = add_s[VW-1:0];
          end
        end else begin
          neg_d = (op_q == rsc_pkg::REQ_MOD) ? a_q[VW-1] : (a_q[VW-1] ^ b_q[VW-1]);
        end
      end
      rsc_pkg::ST_ABS_A: begin
        add_x   = a_q[VW-1] ? '0 : {2'b00, a_q};
        add_y   = a_q[VW-1] ? {2'b00, a_q} : '0;
        add_sub = a_q[VW-1];
        a_d     = add_s[VW-1:0];
      end
      rsc_pkg::ST_ABS_B: begin
        add_x   = b_q[VW-1] ? '0 : {2'b00, b_q};
        add_y   = b_q[VW-1] ? {2'b00, b_q} : '0;
        add_sub = b_q[VW-1];
        b_d     = add_s[VW-1:0];
        lo_d    = add_s[VW-1:0];
        hi_d    = '0;
        rem_d   = '0;
        cnt_d   = '0;
        // The 64-bit dividend sits at the top of dvd so that the loop brings in all of
        // its bits. Divide shifts it up by 16; modulo takes it as it is.
        dvd_d   = (op_q == rsc_pkg::REQ_DIV) ? {a_q, 16'h0000, {VW{1'b0}}}
                                             : {16'h0000, a_q, {VW{1'b0}}};
      end
      rsc_pkg::ST_MUL: begin
        // Shift-and-add: one multiplier bit per cycle, product in {hi, lo}.
        add_x = {2'b00, hi_q};
        add_y = lo_q[0] ? {2'b00, a_q} : '0;
        hi_d  = add_s[VW:1];
        lo_d  = {add_s[0], lo_q[VW-1:1]};
        cnt_d = cnt_q + 1'b1;
      end
      rsc_pkg::ST_DIV: begin
        // Restoring division: one quotient bit per cycle, shifted into dvd.
        add_x   = {1'b0, rem_q, dvd_q[2*VW+15]};
        add_y   = {2'b00, b_q};
        add_sub = 1'b1;
        rem_d   = qbit ? add_s[VW-1:0] : add_x[VW-1:0];
        dvd_d   = {dvd_q[2*VW+14:0], qbit};
        cnt_d   = cnt_q + 1'b1;
      end
      rsc_pkg::ST_PACK: begin
        add_x   = neg_q ? '0 : {2'b00, mag};
        add_y   = neg_q ? {2'b00, mag} : '0;
        add_sub = neg_q;
        if (neg_q) begin
          res_d = (mag_big || (mag[VW-1] && (mag[VW-2:0] != '0))) ?
                  rsc_pkg::VALUE_MIN : add_s[VW-1:0];
        end else begin
          res_d = (mag_big || mag[VW-1]) ? rsc_pkg::VALUE_MAX : add_s[VW-1:0];
        end
      end
      rsc_pkg::ST_PUSH: begin
        // Pops earlier in this item always leave room.
        mem_we = 1'b1;
        sp_d   = sp_q + 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= rsc_pkg::ST_IDLE;
      sp_q        <= '0;
      op_q        <= rsc_pkg::REQ_PUSH;
      status_q    <= rsc_pkg::STS_OK;
      empty_q     <= 1'b0;
      pe_q        <= 1'b0;
      cnt_q       <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      sp_q     <= sp_d;
      op_q     <= op_d;
      status_q <= status_d;
      empty_q  <= empty_d;
      pe_q     <= pe_d;
      cnt_q    <= cnt_d;
      if (rsp_load) begin
        rsp_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        rsp_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    a_q   <= a_d;
    b_q   <= b_d;
    res_q <= res_d;
    neg_q <= neg_d;
    hi_q  <= hi_d;
    lo_q  <= lo_d;
    dvd_q <= dvd_d;
    rem_q <= rem_d;
    if (rsp_load) begin
      rsp_status_q <= final_status;
      // Only a print carries a value; an empty pop on print already read as zero.
      rsp_value_q  <= (final_status == rsc_pkg::STS_PRINTED) ? res_q : '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_q <= mem_q[mem_raddr];
    end
  end

  assign req_i.ready        = (state_q == rsc_pkg::ST_IDLE);
  assign rsp_o.valid        = rsp_valid_q;
  assign rsp_o.status       = rsp_status_q;
  assign rsp_o.result_value = rsp_value_q;

endmodule

`default_nettype wire

@@ rtl/core/rsc_checker.sv @@
// Port-level checker of the RPN calculator and its bind to the top level.
`include "rpn_stack_calculator_defines.svh"
`default_nettype none

module rsc_checker (
  input wire                                clk_i,
  input wire                                rst_ni,
  input wire                                req_valid_i,
  input wire                                req_ready_i,
  input wire                                rsp_valid_i,
  input wire                                rsp_ready_i,
  input wire [rsc_pkg::STATUS_W-1:0]        rsp_status_i,
  input wire [rsc_pkg::VALUE_W-1:0]         rsp_value_i
);

  // A stalled response keeps its status and value.
  `RSC_ASSERT(a_rsp_hold, rsp_valid_i && !rsp_ready_i |=> rsp_valid_i && $stable(rsp_status_i) && $stable(rsp_value_i), "stalled response changed")

  // Only a print response carries a nonzero value.
  `RSC_ASSERT(a_value_zero, rsp_valid_i && (rsp_status_i != rsc_pkg::STS_PRINTED) |-> rsp_value_i == '0, "nonzero value on a response that is not a print")

  // The block works on one request at a time.
  `RSC_ASSERT(a_busy_after_req, req_valid_i && req_ready_i |=> !req_ready_i, "request taken while the previous one is in progress")

endmodule

bind rpn_stack_calculator rsc_checker u_rsc_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .req_valid_i  (req_i.valid),
  .req_ready_i  (req_i.ready),
  .rsp_valid_i  (rsp_o.valid),
  .rsp_ready_i  (rsp_o.ready),
  .rsp_status_i (rsp_o.status),
  .rsp_value_i  (rsp_o.result_value)
);

`default_nettype wire

@@ tb/testbench.sv @@
// Self-checking testbench of the RPN stack calculator: token driver, response checker, predictor.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int VW              = rsc_pkg::VALUE_W;
  localparam int TW              = rsc_pkg::TYPE_W;
  localparam int SW              = rsc_pkg::STATUS_W;
  localparam int CLK_PERIOD      = 20;
  localparam int RESET_CYCLES    = 11;
  localparam int CALC_DEPTH      = 128;
  localparam int N_ITEMS         = 900;
  // The limit sits well above the run time that the slowest tokens would need
  // with the longest gaps on both sides.
  localparam int CYCLE_LIMIT     = 1_000_000;
  localparam int DRAIN_CYCLES    = 120;
  localparam int PRESSURE_AT     = 150;
  localparam int PRESSURE_CYCLES = 400;

  typedef struct packed {
    logic [TW-1:0] kind;
    logic [VW-1:0] value;
  } token_t;

  typedef struct packed {
    logic [SW-1:0] status;
    logic [VW-1:0] result_value;
  } calc_rsp_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  // Testbench-side drivers; they hold known values from time zero.
  logic          drv_valid  = 1'b0;
  logic [TW-1:0] drv_kind   = rsc_pkg::REQ_PUSH;
  logic [VW-1:0] drv_number = '0;
  logic          rsp_ready  = 1'b0;

  rsc_req_if req_if ();
  rsc_rsp_if rsp_if ();

  assign req_if.valid        = drv_valid;
  assign req_if.req_type     = drv_kind;
  assign req_if.number_value = drv_number;
  assign rsp_if.ready        = rsp_ready;

  rpn_stack_calculator #(
    .STACK_DEPTH(CALC_DEPTH)
  ) i_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req_if),
    .rsp_o (rsp_if)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // Tokens waiting to be driven and responses the predictor expects, oldest first.
  token_t    pending_tokens[$];
  calc_rsp_t expected_rsp[$];

  // Predictor state: its own copy of the value stack.
  logic [VW-1:0] calc_stack[CALC_DEPTH];
  int            calc_depth;
  int            calc_peak;
  bit            pop_underflow;
  int            status_seen[8];

  int n_tokens;
  int n_responses;
  int n_errors;
  int cycle_count;
  int gen_depth;

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  function automatic logic [VW-1:0] pop_entry();
    if (calc_depth == 0) begin
      pop_underflow = 1'b1;
      return '0;
    end
    calc_depth--;
    return calc_stack[calc_depth];
  endfunction

  function automatic void push_entry(logic [VW-1:0] v);
    calc_stack[calc_depth] = v;
    calc_depth++;
    if (calc_depth > calc_peak) calc_peak = calc_depth;
  endfunction

  function automatic logic [95:0] magnitude(logic [VW-1:0] v);
    logic [VW-1:0] m;
    m = v[VW-1] ? ('0 - v) : v;
    return {48'd0, m};
  endfunction

  // Sign and magnitude back to a 48-bit value, saturated at both ends.
  function automatic logic [VW-1:0] pack_mag(bit neg, logic [95:0] mag);
    logic [95:0] lim;
    logic [95:0] neg_mag;
    if (neg) begin
      lim = {48'd0, rsc_pkg::VALUE_MIN};
      if (mag > lim) mag = lim;
      neg_mag = '0 - mag;
      return neg_mag[VW-1:0];
    end
    lim = {48'd0, rsc_pkg::VALUE_MAX};
    if (mag > lim) return rsc_pkg::VALUE_MAX;
    return mag[VW-1:0];
  endfunction

  function automatic logic [VW-1:0] sat_sum(logic [VW-1:0] lhs,
                                            logic [VW-1:0] rhs, bit subtract);
    logic signed [VW+1:0] s;
    s = subtract ? ($signed({{2{lhs[VW-1]}}, lhs}) - $signed({{2{rhs[VW-1]}}, rhs}))
                 : ($signed({{2{lhs[VW-1]}}, lhs}) + $signed({{2{rhs[VW-1]}}, rhs}));
    // The sum fits when the three top bits agree.
    if (s[VW+1] != s[VW-1] || s[VW] != s[VW-1])
      return s[VW+1] ? rsc_pkg::VALUE_MIN : rsc_pkg::VALUE_MAX;
    return s[VW-1:0];
  endfunction

  // Applies one accepted token to the predicted stack and queues its response.
  function automatic void apply_token(logic [TW-1:0] kind, logic [VW-1:0] num);
    calc_rsp_t     r;
    logic [VW-1:0] lhs;
    logic [VW-1:0] rhs;
    r.status       = rsc_pkg::STS_OK;
    r.result_value = '0;
    pop_underflow  = 1'b0;
    case (kind)
      rsc_pkg::REQ_PUSH: begin
        if (calc_depth < CALC_DEPTH) push_entry(num);
        else r.status = rsc_pkg::STS_FULL;
      end
      rsc_pkg::REQ_ADD, rsc_pkg::REQ_SUB: begin
        rhs = pop_entry();
        lhs = pop_entry();
        push_entry(sat_sum(lhs, rhs, kind == rsc_pkg::REQ_SUB));
      end
      rsc_pkg::REQ_MUL: begin
        rhs = pop_entry();
        lhs = pop_entry();
        push_entry(pack_mag(lhs[VW-1] ^ rhs[VW-1],
                            (magnitude(lhs) * magnitude(rhs)) >> 16));
      end
      rsc_pkg::REQ_DIV, rsc_pkg::REQ_MOD: begin
        rhs = pop_entry();
        // A zero divisor is consumed and the dividend stays where it is.
        if (rhs == '0) begin
          r.status = rsc_pkg::STS_ZERO_DIV;
        end else begin
          lhs = pop_entry();
          if (kind == rsc_pkg::REQ_DIV)
            push_entry(pack_mag(lhs[VW-1] ^ rhs[VW-1],
                                (magnitude(lhs) << 16) / magnitude(rhs)));
          else
            push_entry(pack_mag(lhs[VW-1], magnitude(lhs) % magnitude(rhs)));
        end
      end
      rsc_pkg::REQ_PRINT: begin
        r.result_value = pop_entry();
        r.status       = rsc_pkg::STS_PRINTED;
      end
      default: r.status = rsc_pkg::STS_UNKNOWN;
    endcase
    // Any pop from an empty stack overrides the status of the whole token.
    if (pop_underflow) begin
      r.status       = rsc_pkg::STS_EMPTY;
      r.result_value = '0;
    end
    status_seen[r.status]++;
    expected_rsp.push_back(r);
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  function automatic logic [VW-1:0] to_fixed(int n);
    logic [VW-1:0] v;
    v = VW'(n);
    return v << 16;
  endfunction

  function automatic logic [VW-1:0] random_value();
    int w;
    case ($urandom_range(0, 11))
      0:       return rsc_pkg::VALUE_MIN;
      1:       return rsc_pkg::VALUE_MAX;
      2:       return '0;
      3:       return to_fixed(int'($urandom_range(0, 200)) - 100);
      4:       return $urandom_range(0, 1) ? VW'(1) : '1;
      5, 6: begin
        w = $urandom;
        return VW'(w);
      end
      default: return VW'({$urandom, $urandom});
    endcase
  endfunction

  // Queues a token and keeps a rough depth estimate that never runs above
  // the real depth, so a fill burst always reaches a full stack.
  function automatic void queue_token(logic [TW-1:0] kind, logic [VW-1:0] value);
    token_t t;
    t.kind  = kind;
    t.value = value;
    pending_tokens.push_back(t);
    case (kind)
      rsc_pkg::REQ_PUSH:  if (gen_depth < CALC_DEPTH) gen_depth++;
      rsc_pkg::REQ_ADD, rsc_pkg::REQ_SUB, rsc_pkg::REQ_MUL:
        gen_depth = (gen_depth >= 2) ? gen_depth - 1 : 1;
      rsc_pkg::REQ_DIV, rsc_pkg::REQ_MOD:
        gen_depth = (gen_depth >= 2) ? gen_depth - 1 : 0;
      rsc_pkg::REQ_PRINT: if (gen_depth > 0) gen_depth--;
      default:            ;
    endcase
  endfunction

  function automatic void queue_fill();
    while (gen_depth < CALC_DEPTH) queue_token(rsc_pkg::REQ_PUSH, random_value());
    repeat ($urandom_range(2, 5)) queue_token(rsc_pkg::REQ_PUSH, random_value());
  endfunction

  // One step of a well-formed expression: keep a short stack and apply operators.
  function automatic void queue_expression_step();
    int pct;
    pct = (gen_depth < 6) ? 50 : 15;
    if (gen_depth < 2 || $urandom_range(0, 99) < pct) begin
      queue_token(rsc_pkg::REQ_PUSH, random_value());
    end else begin
      case ($urandom_range(0, 5))
        0:       queue_token(rsc_pkg::REQ_ADD, random_value());
        1:       queue_token(rsc_pkg::REQ_SUB, random_value());
        2:       queue_token(rsc_pkg::REQ_MUL, random_value());
        3:       queue_token(rsc_pkg::REQ_DIV, random_value());
        4:       queue_token(rsc_pkg::REQ_MOD, random_value());
        default: queue_token(rsc_pkg::REQ_PRINT, random_value());
      endcase
    end
  endfunction

  function automatic int pick_gap(bit burst);
    int r;
    if (burst) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // ---------------------------------------------------------------------------
  // Token driver: one transfer per accepted token, random gaps between them.
  // ---------------------------------------------------------------------------

  int     req_gap;
  bit     req_burst;
  token_t next_token;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      drv_valid  <= 1'b0;
      drv_kind   <= rsc_pkg::REQ_PUSH;
      drv_number <= '0;
      req_gap    = 0;
      req_burst  = 1'b0;
    end else begin
      if (drv_valid && req_if.ready) begin
        apply_token(drv_kind, drv_number);
        n_tokens++;
        req_gap = pick_gap(req_burst);
        if ($urandom_range(0, 99) == 0) req_burst = !req_burst;
      end
      if (!drv_valid || req_if.ready) begin
        if (req_gap == 0 && pending_tokens.size() != 0) begin
          next_token = pending_tokens.pop_front();
          drv_valid  <= 1'b1;
          drv_kind   <= next_token.kind;
          drv_number <= next_token.value;
        end else begin
          drv_valid <= 1'b0;
          if (req_gap > 0) req_gap--;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Long hold-off of the receiver that backs the block up, counted on its own.
  // ---------------------------------------------------------------------------

  int pressure_left;
  bit pressure_done;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pressure_left <= 0;
      pressure_done <= 1'b0;
    end else if (pressure_left > 0) begin
      pressure_left <= pressure_left - 1;
    end else if (!pressure_done && n_responses >= PRESSURE_AT) begin
      pressure_left <= PRESSURE_CYCLES;
      pressure_done <= 1'b1;
    end
  end

  // ---------------------------------------------------------------------------
  // Response checker: compares each transfer with the oldest expectation and
  // stalls at random.
  // ---------------------------------------------------------------------------

  int        rsp_stall;
  bit        rsp_burst;
  calc_rsp_t want;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_ready <= 1'b0;
      rsp_stall = 0;
      rsp_burst = 1'b0;
    end else begin
      if (rsp_if.valid && rsp_if.ready) begin
        n_responses++;
        if (expected_rsp.size() == 0) begin
          $error("response without an outstanding token: status %0d, result_value %0h",
                 rsp_if.status, rsp_if.result_value);
          n_errors++;
        end else begin
          want = expected_rsp.pop_front();
          if (rsp_if.status !== want.status) begin
            $error("status mismatch: expected %0d, actual %0d", want.status, rsp_if.status);
            n_errors++;
          end
          if (rsp_if.result_value !== want.result_value) begin
            $error("result_value mismatch: expected %0h, actual %0h",
                   want.result_value, rsp_if.result_value);
            n_errors++;
          end
        end
        rsp_stall = pick_gap(rsp_burst);
        if ($urandom_range(0, 99) == 0) rsp_burst = !rsp_burst;
      end
      if (pressure_left > 0) begin
        rsp_ready <= 1'b0;
      end else if (rsp_stall > 0) begin
        rsp_stall--;
        rsp_ready <= 1'b0;
      end else begin
        rsp_ready <= 1'b1;
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $error("timeout: %0d tokens unsent, %0d responses outstanding",
             pending_tokens.size(), expected_rsp.size());
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus and end of run
  // ---------------------------------------------------------------------------

  initial begin
    bit filled;
    int sel;

    // Directed part: empty-stack pops, zero divisors, saturation at both ends.
    queue_token(rsc_pkg::REQ_PRINT, '0);           // print of an empty stack
    queue_token(rsc_pkg::REQ_ADD, '0);             // add on empty pushes zero
    queue_token(rsc_pkg::REQ_DIV, '0);             // divisor is that zero
    queue_token(rsc_pkg::REQ_MOD, '0);             // empty and zero divisor together
    queue_token(rsc_pkg::REQ_PUSH, to_fixed(5));
    queue_token(rsc_pkg::REQ_DIV, '0);             // dividend pop finds the stack empty
    queue_token(rsc_pkg::REQ_UNKNOWN, rsc_pkg::VALUE_MAX);
    queue_token(rsc_pkg::REQ_PUSH, rsc_pkg::VALUE_MAX);
    queue_token(rsc_pkg::REQ_ADD, '0);
    queue_token(rsc_pkg::REQ_PUSH, rsc_pkg::VALUE_MAX);
    queue_token(rsc_pkg::REQ_ADD, '0);             // saturates high
    queue_token(rsc_pkg::REQ_PRINT, '0);
    queue_token(rsc_pkg::REQ_PUSH, rsc_pkg::VALUE_MIN);
    queue_token(rsc_pkg::REQ_PUSH, VW'(1));
    queue_token(rsc_pkg::REQ_SUB, '0);             // saturates low
    queue_token(rsc_pkg::REQ_PUSH, to_fixed(-1));
    queue_token(rsc_pkg::REQ_MUL, '0);             // most negative times -1
    queue_token(rsc_pkg::REQ_PUSH, rsc_pkg::VALUE_MIN);
    queue_token(rsc_pkg::REQ_PUSH, to_fixed(-1));
    queue_token(rsc_pkg::REQ_DIV, '0);             // most negative over -1
    queue_token(rsc_pkg::REQ_PUSH, to_fixed(-7));
    queue_token(rsc_pkg::REQ_PUSH, to_fixed(2));
    queue_token(rsc_pkg::REQ_MOD, '0);             // remainder takes the dividend's sign
    queue_token(rsc_pkg::REQ_PUSH, '0);
    queue_token(rsc_pkg::REQ_MOD, '0);

    // Random part: mostly well-formed expressions, with noise, full-stack
    // bursts and runs of prints that empty the stack and pop past it.
    filled = 1'b0;
    while (pending_tokens.size() < N_ITEMS) begin
      sel = $urandom_range(0, 999);
      if ((!filled && pending_tokens.size() > 200) || sel < 2) begin
        queue_fill();
        filled = 1'b1;
      end else if (sel < 30) begin
        repeat (gen_depth + $urandom_range(1, 3))
          queue_token(rsc_pkg::REQ_PRINT, random_value());
      end else if (sel < 130) begin
        queue_token(TW'($urandom_range(0, 7)), random_value());
      end else begin
        queue_expression_step();
      end
    end

    repeat (RESET_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    while (pending_tokens.size() != 0 || drv_valid) @(posedge clk_i);
    while (expected_rsp.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Run drove %0d tokens and checked %0d responses; the stack reached depth %0d.",
             n_tokens, n_responses, calc_peak);
    $display("Statuses: ok %0d, printed %0d, zero divisor %0d, full %0d, empty %0d, unknown %0d.",
             status_seen[rsc_pkg::STS_OK], status_seen[rsc_pkg::STS_PRINTED],
             status_seen[rsc_pkg::STS_ZERO_DIV], status_seen[rsc_pkg::STS_FULL],
             status_seen[rsc_pkg::STS_EMPTY], status_seen[rsc_pkg::STS_UNKNOWN]);
    if (n_errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

@@ files.f @@
+incdir+rtl/core
rtl/core/rsc_pkg.sv
rtl/core/rsc_req_if.sv
rtl/core/rsc_rsp_if.sv
rtl/core/rpn_stack_calculator.sv
rtl/core/rsc_checker.sv
tb/testbench.sv
